// File: hdl/ics_pkg.sv
package ics_pkg;

   localparam int MAX_INTERVALS = 64;
   localparam int NUM_POSITIONS = 4096;
   localparam int POS_W = 13;
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
   localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

   typedef struct packed {
      logic [POS_W-1:0] start_pos;
      logic [POS_W-1:0] span_len;
      logic [63:0]      score_bits;
      logic [63:0]      odds_bits;
      logic [63:0]      pval_bits;
      logic             final_item;
   } ics_req_type;

   typedef struct packed {
      logic [POS_W-1:0] best_start;
      logic [POS_W-1:0] best_end;
      logic [63:0]      best_score;
      logic [63:0]      best_odds;
      logic [63:0]      best_pval;
      logic [6:0]       member_count;
      logic [POS_W-1:0] cluster_left;
      logic [POS_W-1:0] cluster_right;
      logic             last_cluster;
   } ics_rsp_type;

   // clipped interval as stored
   typedef struct packed {
      logic [POS_W-1:0] lo;
      logic [POS_W-1:0] len;
      logic [POS_W-1:0] hi;
      logic [63:0]      score;
      logic [63:0]      odds;
      logic [63:0]      pval;
   } ics_ivl_type;

   // queue entry between front and back
   typedef struct packed {
      ics_ivl_type ivl;
      logic        keep;
      logic        fin;
   } ics_ent_type;

endpackage

// File: hdl/ics_front.sv
module ics_front
   import ics_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ics_req_type req_data,
   output logic        q_valid,
   output ics_ent_type q_head,
   input  logic        q_pop
);

   ics_ent_type      qmem_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;
   ics_ent_type      ent;
   logic [POS_W:0]   e14, hi14;
   logic [POS_W-1:0] lo;
   logic             push, pop;

   always_comb begin
      e14  = {1'b0, req_data.start_pos} + {1'b0, req_data.span_len} - {{POS_W{1'b0}}, 1'b1};
      lo   = (req_data.start_pos == '0) ? POS_W'(1) : req_data.start_pos;
      hi14 = (e14 > (POS_W+1)'(NUM_POSITIONS)) ? (POS_W+1)'(NUM_POSITIONS) : e14;
      ent.ivl.lo    = lo;
      ent.ivl.hi    = hi14[POS_W-1:0];
      ent.ivl.len   = hi14[POS_W-1:0] - lo + POS_W'(1);
      ent.ivl.score = req_data.score_bits;
      ent.ivl.odds  = req_data.odds_bits;
      ent.ivl.pval  = req_data.pval_bits;
      // zero length, or nothing left after clipping: dropped but final still acts
      ent.keep = (req_data.span_len != '0) && ({1'b0, lo} <= hi14);
      ent.fin  = req_data.final_item;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_head    = qmem_ff[rp_ff];
   assign pop       = q_pop && q_valid;

   always_ff @(posedge clock) begin
      if (push) qmem_ff[wp_ff] <= ent;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// File: hdl/ics_back.sv
module ics_back
   import ics_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  ics_ent_type q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ics_rsp_type rsp_data
);

   typedef enum logic [1:0] {ST_LOAD, ST_FIND, ST_GROW, ST_EMIT} state_type;

   state_type            state_ff;
   ics_ivl_type          mem [MAX_INTERVALS];
   ics_ivl_type          rd_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic [CNT_W-1:0]     n_ff, iss_ff, done_ff, count_ff;
   logic                 pv_ff;
   logic [IDX_W-1:0]     pidx_ff;
   logic [MAX_INTERVALS-1:0] asg_ff;
   logic                 changed_ff, seed_ff;
   logic [POS_W-1:0]     left_ff, right_ff;
   ics_ivl_type          best_ff;
   logic [IDX_W-1:0]     bidx_ff;
   logic                 rsp_valid_ff;
   ics_rsp_type          rsp_ff;
   logic                 slot_free, scan_done, joins, better, last;
   logic [CNT_W-1:0]     n_next;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == ST_LOAD) && q_valid;
   assign rd_addr   = iss_ff[IDX_W-1:0];
   assign scan_done = (iss_ff == n_ff) && !pv_ff;
   assign joins     = pv_ff && !asg_ff[pidx_ff]
                      && ({1'b0, rd_ff.lo} <= {1'b0, right_ff} + (POS_W+1)'(1));
   // strict order: pval, length, start, then load index
   always_comb begin
      if (rd_ff.pval != best_ff.pval)     better = rd_ff.pval < best_ff.pval;
      else if (rd_ff.len != best_ff.len)  better = rd_ff.len < best_ff.len;
      else if (rd_ff.lo != best_ff.lo)    better = rd_ff.lo < best_ff.lo;
      else                                better = pidx_ff < bidx_ff;
   end
   assign last   = ((done_ff + count_ff) == n_ff);
   assign n_next = n_ff + CNT_W'(q_head.keep && (n_ff < CNT_W'(MAX_INTERVALS)));

   always_ff @(posedge clock) begin
      if (q_pop && q_head.keep && (n_ff < CNT_W'(MAX_INTERVALS)))
         mem[n_ff[IDX_W-1:0]] <= q_head.ivl;
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         n_ff         <= '0;
         iss_ff       <= '0;
         pv_ff        <= 1'b0;
         done_ff      <= '0;
         count_ff     <= '0;
         asg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_EMIT && slot_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_FIND || state_ff == ST_GROW) begin
            if (iss_ff != n_ff) begin
               iss_ff  <= iss_ff + CNT_W'(1);
               pidx_ff <= iss_ff[IDX_W-1:0];
               pv_ff   <= 1'b1;
            end else begin
               pv_ff <= 1'b0;
            end
         end
         case (state_ff)
            ST_LOAD: begin
               if (q_pop) begin
                  n_ff <= n_next;
                  if (q_head.fin && n_next != '0) begin
                     state_ff <= ST_FIND;
                     asg_ff   <= '0;
                     done_ff  <= '0;
                     iss_ff   <= '0;
                     pv_ff    <= 1'b0;
                     seed_ff  <= 1'b0;
                  end
               end
            end
            ST_FIND: begin
               if (pv_ff && !asg_ff[pidx_ff] && (!seed_ff || rd_ff.lo < left_ff)) begin
                  seed_ff  <= 1'b1;
                  left_ff  <= rd_ff.lo;
                  right_ff <= rd_ff.hi;
               end
               if (scan_done) begin
                  state_ff   <= ST_GROW;
                  iss_ff     <= '0;
                  count_ff   <= '0;
                  changed_ff <= 1'b0;
               end
            end
            ST_GROW: begin
               if (joins) begin
                  asg_ff[pidx_ff] <= 1'b1;
                  count_ff        <= count_ff + CNT_W'(1);
                  changed_ff      <= 1'b1;
                  if (rd_ff.hi > right_ff) right_ff <= rd_ff.hi;
                  if (count_ff == '0 || better) begin
                     best_ff <= rd_ff;
                     bidx_ff <= pidx_ff;
                  end
               end
               if (scan_done) begin
                  if (changed_ff) begin
                     iss_ff     <= '0;
                     changed_ff <= 1'b0;
                  end else begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_EMIT: begin
               if (slot_free) begin
                  rsp_ff.best_start    <= best_ff.lo;
                  rsp_ff.best_end      <= best_ff.hi;
                  rsp_ff.best_score    <= best_ff.score;
                  rsp_ff.best_odds     <= best_ff.odds;
                  rsp_ff.best_pval     <= best_ff.pval;
                  rsp_ff.member_count  <= 7'(count_ff);
                  rsp_ff.cluster_left  <= left_ff;
                  rsp_ff.cluster_right <= right_ff;
                  rsp_ff.last_cluster  <= last;
                  done_ff              <= done_ff + count_ff;
                  if (last) begin
                     state_ff <= ST_LOAD;
                     n_ff     <= '0;
                  end else begin
                     state_ff <= ST_FIND;
                     iss_ff   <= '0;
                     seed_ff  <= 1'b0;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GROW || state_ff == ST_EMIT) |-> (done_ff + count_ff <= n_ff))
      else $error("assigned intervals exceed loaded count");
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (count_ff != '0))
      else $error("cluster emitted with no members");
   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && slot_free && last) |=> (n_ff == '0))
      else $error("set not cleared after final cluster");

endmodule

// File: hdl/interval_cluster_best_select_core.sv
// Load items: accepted one per cycle while the two-entry queue has room; each
// is stored by the back end as it pops it from the queue while loading.
// Final item: for each cluster the back end scans the stored set for its seed,
// then makes growth passes (at least two) until a pass adds no member, then
// registers the result. No items are taken from the queue meanwhile.
// Reset (synchronous) empties the queue and the set; no clearing pass.
module interval_cluster_best_select_core
   import ics_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ics_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ics_rsp_type rsp_data
);

   logic        q_valid, q_pop;
   ics_ent_type q_head;

   ics_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   ics_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import ics_pkg::*;

   localparam int IDLE_LIMIT = 50000;

   typedef struct {
      ics_req_type item;
      bit          typed;   // expected result written out below
      int          n_rsp;
      ics_rsp_type rsp;
   } stim_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ics_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ics_rsp_type rsp_data;

   ics_rsp_type cluster_q[$];
   ics_ivl_type held_ivl[$];
   bit          covered[1:NUM_POSITIONS];
   int          error_count = 0;
   int          idle_cycles = 0;
   int          stall_left = 0;
   bit          quiet = 0;

   interval_cluster_best_select_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit beats(ics_ivl_type a, ics_ivl_type b);
      if (a.pval != b.pval) return a.pval < b.pval;
      if (a.len != b.len) return a.len < b.len;
      return a.lo < b.lo;
   endfunction

   // loads one interval; on the final item returns one result per cluster
   function automatic void load_interval(input ics_req_type it, ref ics_rsp_type res[$]);
      int          lo, hi, p, a, b, cnt, left, right, e;
      ics_ivl_type ivl, best;
      ics_rsp_type r;
      res.delete();
      if (it.span_len != 0 && held_ivl.size() < MAX_INTERVALS) begin
         lo = (it.start_pos < 1) ? 1 : int'(it.start_pos);
         hi = int'(it.start_pos) + int'(it.span_len) - 1;
         if (hi > NUM_POSITIONS) hi = NUM_POSITIONS;
         if (lo <= hi) begin
            ivl.lo = POS_W'(lo);
            ivl.len = POS_W'(hi - lo + 1);
            ivl.hi = POS_W'(hi);
            ivl.score = it.score_bits;
            ivl.odds = it.odds_bits;
            ivl.pval = it.pval_bits;
            held_ivl.insert(held_ivl.size(), ivl);
            for (int q = lo; q <= hi; q++) covered[q] = 1;
         end
      end
      if (!it.final_item) return;
      p = 1;
      while (p <= NUM_POSITIONS) begin
         if (!covered[p]) begin
            p++;
            continue;
         end
         a = p;
         while (p <= NUM_POSITIONS && covered[p]) p++;
         b = p - 1;
         cnt = 0;
         foreach (held_ivl[i]) begin
            if (held_ivl[i].lo < a || held_ivl[i].lo > b) continue;
            e = int'(held_ivl[i].lo) + int'(held_ivl[i].len) - 1;
            if (cnt == 0) begin
               best = held_ivl[i];
               left = held_ivl[i].lo;
               right = e;
            end else begin
               if (beats(held_ivl[i], best)) best = held_ivl[i];
               if (held_ivl[i].lo < left) left = held_ivl[i].lo;
               if (e > right) right = e;
            end
            cnt++;
         end
         if (cnt == 0 || res.size() >= MAX_INTERVALS) continue;
         r.best_start = best.lo;
         r.best_end = best.lo + best.len - 1;
         r.best_score = best.score;
         r.best_odds = best.odds;
         r.best_pval = best.pval;
         r.member_count = 7'(cnt);
         r.cluster_left = POS_W'(left);
         r.cluster_right = POS_W'(right);
         r.last_cluster = 0;
         res.insert(res.size(), r);
      end
      if (res.size() > 0) res[res.size()-1].last_cluster = 1;
      held_ivl.delete();
      covered = '{default: 0};
   endfunction

   task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
      $display("%0t mismatch %s: got %h, expected %h", $time, field, got, want);
      error_count++;
   endtask

   // accepted results
   always @(posedge clock) begin
      ics_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cluster_q.size() == 0) begin
            report("unexpected item", rsp_data.best_pval, '0);
         end else begin
            want = cluster_q.pop_front();
            if (rsp_data.best_start !== want.best_start)
               report("best_start", 64'(rsp_data.best_start), 64'(want.best_start));
            if (rsp_data.best_end !== want.best_end)
               report("best_end", 64'(rsp_data.best_end), 64'(want.best_end));
            if (rsp_data.best_score !== want.best_score)
               report("best_score", rsp_data.best_score, want.best_score);
            if (rsp_data.best_odds !== want.best_odds)
               report("best_odds", rsp_data.best_odds, want.best_odds);
            if (rsp_data.best_pval !== want.best_pval)
               report("best_pval", rsp_data.best_pval, want.best_pval);
            if (rsp_data.member_count !== want.member_count)
               report("member_count", 64'(rsp_data.member_count), 64'(want.member_count));
            if (rsp_data.cluster_left !== want.cluster_left)
               report("cluster_left", 64'(rsp_data.cluster_left), 64'(want.cluster_left));
            if (rsp_data.cluster_right !== want.cluster_right)
               report("cluster_right", 64'(rsp_data.cluster_right),
                      64'(want.cluster_right));
            if (rsp_data.last_cluster !== want.last_cluster)
               report("last_cluster", 64'(rsp_data.last_cluster), 64'(want.last_cluster));
         end
      end
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[interval_cluster_best_select_core] ERROR");
         $finish;
      end
   end

   task automatic send(input ics_req_type it, input int gap, input bit typed,
                       input int n_rsp, input ics_rsp_type rsp);
      ics_rsp_type res[$];
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      load_interval(it, res);
      if (typed) begin
         if (n_rsp > 0) cluster_q.insert(cluster_q.size(), rsp);
      end else begin
         foreach (res[i]) cluster_q.insert(cluster_q.size(), res[i]);
      end
   endtask

   function automatic ics_req_type mk(int s, int l, logic [63:0] pv, bit fin);
      ics_req_type it;
      it.start_pos = POS_W'(s);
      it.span_len = POS_W'(l);
      it.score_bits = {$urandom, $urandom};
      it.odds_bits = {$urandom, $urandom};
      it.pval_bits = pv;
      it.final_item = fin;
      return it;
   endfunction

   function automatic int pick_gap();
      if (quiet || $urandom_range(0, 3) != 0) return 0;
      return $urandom_range(1, 5);
   endfunction

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      ics_req_type  it;
      int           sent, set_len, s;
      bit           full_done;
      logic [63:0]  pv;

      // single positions at both ends of the map, then clipping and empty sets
      row = '{mk(1, 1, 64'h0, 1), 1, 1, '0};
      row.rsp = '{1, 1, row.item.score_bits, row.item.odds_bits, 64'h0, 1, 1, 1, 1};
      rows.insert(rows.size(), row);
      row = '{mk(8191, 8191, '1, 0), 0, 0, '0};   // beyond the map: ignored
      rows.insert(rows.size(), row);
      row = '{mk(4096, 8191, '1, 1), 1, 1, '0};
      row.item.score_bits = '1;
      row.item.odds_bits = '1;
      row.rsp = '{4096, 4096, '1, '1, '1, 1, 4096, 4096, 1};
      rows.insert(rows.size(), row);
      row = '{mk(0, 1, 64'h5, 1), 1, 0, '0};      // clipped to nothing, empty set
      rows.insert(rows.size(), row);
      row = '{mk(0, 8191, 64'h7, 1), 1, 1, '0};
      row.rsp = '{1, 4096, row.item.score_bits, row.item.odds_bits, 64'h7, 1, 1, 4096, 1};
      rows.insert(rows.size(), row);
      row = '{mk(20, 0, 64'h0, 1), 1, 0, '0};     // zero length, empty set
      rows.insert(rows.size(), row);
      // ties: pval, then length, then start, then load order; touching spans merge
      rows.insert(rows.size(), '{mk(10, 3, 64'h10, 0), 0, 0, '0});
      rows.insert(rows.size(), '{mk(13, 3, 64'h10, 0), 0, 0, '0});
      rows.insert(rows.size(), '{mk(11, 2, 64'h10, 0), 0, 0, '0});
      rows.insert(rows.size(), '{mk(40, 5, 64'h3, 0), 0, 0, '0});
      rows.insert(rows.size(), '{mk(38, 5, 64'h3, 0), 0, 0, '0});
      rows.insert(rows.size(), '{mk(38, 5, 64'h3, 0), 0, 0, '0});
      rows.insert(rows.size(), '{mk(60, 4, 64'h2, 0), 0, 0, '0});
      rows.insert(rows.size(), '{mk(62, 9, 64'h1, 0), 0, 0, '0});
      rows.insert(rows.size(), '{mk(4090, 20, 64'h0, 0), 0, 0, '0});
      rows.insert(rows.size(), '{mk(0, 3, 64'h9, 0), 0, 0, '0});
      rows.insert(rows.size(), '{mk(0, 0, 64'h0, 1), 0, 0, '0});   // final flag on ignored item

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send(rows[i].item, pick_gap(), rows[i].typed, rows[i].n_rsp, rows[i].rsp);

      sent = 0;
      full_done = 0;
      while (sent < 145) begin
         if (sent > 120) quiet = 1;
         if (!full_done && sent > 40) begin
            set_len = $urandom_range(66, 70);   // overflow the store
            full_done = 1;
         end else begin
            set_len = $urandom_range(1, 8);
         end
         // hold off until every expected result has come
         if (sent > 20 && sent < 40 && cluster_q.size() != 0) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (cluster_q.size() != 0);
         end
         for (int k = 0; k < set_len; k++) begin
            case ($urandom_range(0, 2))
               0: pv = $urandom_range(0, 2);
               default: pv = {$urandom, $urandom};
            endcase
            s = (set_len > 20) ? k * 70 + $urandom_range(0, 80) : $urandom_range(1, 300);
            if ($urandom_range(0, 9) == 0)
               it = mk($urandom_range(0, 8191), $urandom_range(0, 8191), pv, 0);
            else if ($urandom_range(0, 19) == 0)
               it = mk(s, 0, pv, 0);
            else
               it = mk(s, $urandom_range(1, 30), pv, 0);
            it.final_item = (k == set_len - 1);
            send(it, pick_gap(), 0, 0, '0);
            sent++;
         end
      end
      req_valid <= 1'b0;
      wait (cluster_q.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("[interval_cluster_best_select_core] OK");
      else
         $display("[interval_cluster_best_select_core] ERROR");
      $finish;
   end

endmodule
